[design/slb_pkg.sv]
// Package for the SQL lexer byte stream block: widths, token kinds, keyword table.
// No dependencies.
`timescale 1ns / 1ps
package slb_pkg;
    localparam int POSITION_BITS = 16;
    localparam int KEYWORD_CHARS = 10;
    localparam int KEYWORD_COUNT = 57;
    localparam int OUT_BITS = 16;
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    localparam logic [2:0] KIND_KEYWORD = 3'd0;
    localparam logic [2:0] KIND_IDENT = 3'd1;
    localparam logic [2:0] KIND_LITERAL = 3'd2;
    localparam logic [2:0] KIND_OPERATOR = 3'd3;
    localparam logic [2:0] KIND_PUNCT = 3'd4;
    localparam logic [2:0] KIND_EOF = 3'd5;

    typedef logic [KEYWORD_CHARS*8-1:0] t_word;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic [5:0]  keyword_number;
        logic [7:0]  first_symbol;
        logic [7:0]  second_symbol;
        logic        last;
    } t_token;

    // A classified byte: up to two tokens, the first possibly a word to look up.
    typedef struct packed {
        logic   v0;
        logic   v0_word;
        t_word  word;
        logic   word_long;
        t_token t0;
        logic   v1;
        t_token t1;
    } t_pair;

    function automatic t_word kw_text(input int k);
        string s;
        t_word w;
        s = "";
        case (k)
            0: s = "SELECT";      1: s = "DISTINCT";  2: s = "FROM";     3: s = "WHERE";
            4: s = "GROUP";       5: s = "BY";        6: s = "ORDER";    7: s = "AND";
            8: s = "OR";          9: s = "NOT";       10: s = "IN";      11: s = "AS";
            12: s = "ASC";        13: s = "DESC";     14: s = "HAVING";  15: s = "JOIN";
            16: s = "LEFT";       17: s = "RIGHT";    18: s = "INNER";   19: s = "OUTER";
            20: s = "FULL";       21: s = "ON";       22: s = "LIMIT";   23: s = "OFFSET";
            24: s = "LIKE";       25: s = "ILIKE";    26: s = "UNION";   27: s = "INTERSECT";
            28: s = "EXCEPT";     29: s = "ALL";      30: s = "BETWEEN"; 31: s = "INSERT";
            32: s = "INTO";       33: s = "VALUES";   34: s = "UPDATE";  35: s = "SET";
            36: s = "DELETE";     37: s = "CREATE";   38: s = "TABLE";   39: s = "ALTER";
            40: s = "RENAME";     41: s = "COLUMN";   42: s = "ADD";     43: s = "DROP";
            44: s = "TO";         45: s = "CASE";     46: s = "WHEN";    47: s = "THEN";
            48: s = "ELSE";       49: s = "END";      50: s = "OVER";    51: s = "PARTITION";
            52: s = {"ROW", "_NUMBER"};   53: s = "RANK";
            54: s = {"DENSE", "_RANK"};   55: s = "LAG";
            56: s = "LEAD";
            default: s = "";
        endcase
        w = '0;
        for (int i = 0; i < KEYWORD_CHARS; i++) begin
            if (i < s.len()) w[i*8 +: 8] = s[i];
        end
        return w;
    endfunction

    function automatic logic [15:0] clamp16(input logic [POSITION_BITS:0] v);
        logic [15:0] r;
        r = (v > (POSITION_BITS+1)'(16'hFFFF)) ? 16'hFFFF : v[15:0];
        return r;
    endfunction
endpackage

[design/slb_if.sv]
// Valid/ready channel interfaces for the lexer input and token output.
// No dependencies.
`timescale 1ns / 1ps
interface slb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;
    modport source(output valid, text_byte, end_of_text, input ready);
    modport sink(input valid, text_byte, end_of_text, output ready);
endinterface

interface slb_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [5:0]  keyword_number;
    logic [7:0]  first_symbol;
    logic [7:0]  second_symbol;
    logic        last;
    modport source(output valid, token_kind, token_start, token_length, keyword_number,
                   first_symbol, second_symbol, last, input ready);
    modport sink(input valid, token_kind, token_start, token_length, keyword_number,
                 first_symbol, second_symbol, last, output ready);
endinterface

[design/slb_front.sv]
// Front end: scanner state machine, one byte per cycle while the queue has room, producing token pairs.
// Depends on slb_pkg.
`timescale 1ns / 1ps
module slb_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_byte,
    input  logic                i_end,
    output logic                o_ready,
    output logic                o_push,
    output slb_pkg::t_pair      o_pair,
    input  logic                i_room
);
    typedef enum logic [2:0] {
        MODE_IDLE, MODE_HELD, MODE_IDENT, MODE_NUMBER, MODE_STRING, MODE_LINE, MODE_BLOCK
    } t_mode;

    localparam int PB = slb_pkg::POSITION_BITS;
    localparam int KC = slb_pkg::KEYWORD_CHARS;

    t_mode r_mode, n_mode;
    logic r_dq, n_dq, r_star, n_star, r_long, n_long;
    logic [7:0] r_held, n_held;
    logic [PB-1:0] r_pos, n_pos, r_beg, n_beg;
    slb_pkg::t_word r_word, n_word;
    logic [$clog2(KC+1)-1:0] r_wlen, n_wlen;
    slb_pkg::t_pair pr;

    logic fire;
    assign o_ready = i_room;
    assign fire = i_valid && i_room;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction
    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic slb_pkg::t_token mk(input logic [2:0] k, input logic [PB-1:0] s,
                                           input logic [PB:0] l, input logic [7:0] a,
                                           input logic [7:0] b, input logic lst);
        slb_pkg::t_token t;
        t.token_kind = k;
        t.token_start = slb_pkg::clamp16({1'b0, s});
        t.token_length = slb_pkg::clamp16(l);
        t.keyword_number = '0;
        t.first_symbol = a;
        t.second_symbol = b;
        t.last = lst;
        return t;
    endfunction

    logic [PB:0] len_now;
    logic [7:0] cu;
    assign len_now = {1'b0, r_pos} - {1'b0, r_beg};
    assign cu = (i_byte >= "a" && i_byte <= "z") ? i_byte - 8'd32 : i_byte;

    always_comb begin
        logic fresh, em_word, em_held;
        n_mode = r_mode; n_dq = r_dq; n_star = r_star; n_long = r_long;
        n_held = r_held; n_pos = r_pos; n_beg = r_beg; n_word = r_word; n_wlen = r_wlen;
        pr = '0;
        fresh = 1'b0;
        em_word = 1'b0;
        em_held = 1'b0;
        if (i_end || i_byte == 8'd0) begin
            if (r_mode == MODE_IDENT) em_word = 1'b1;
            else if (r_mode == MODE_NUMBER) begin
                pr.v0 = 1'b1;
                pr.t0 = mk(slb_pkg::KIND_LITERAL, r_beg, len_now, 8'd0, 8'd0, 1'b0);
            end else if (r_mode == MODE_HELD && r_held != "!") begin
                pr.v0 = 1'b1;
                pr.t0 = mk(slb_pkg::KIND_OPERATOR, r_beg, (PB+1)'(1), r_held, 8'd0, 1'b0);
            end
            pr.v1 = 1'b1;
            pr.t1 = mk(slb_pkg::KIND_EOF, r_pos, '0, 8'd0, 8'd0, 1'b1);
            n_mode = MODE_IDLE; n_dq = 1'b0; n_star = 1'b0; n_long = 1'b0;
            n_held = '0; n_pos = '0; n_beg = '0; n_word = '0; n_wlen = '0;
        end else begin
            case (r_mode)
                MODE_IDENT: begin
                    if (is_alpha(i_byte) || is_digit(i_byte) || i_byte == "_") begin
                        if (r_wlen < ($bits(r_wlen))'(KC)) begin
                            n_word[r_wlen*8 +: 8] = cu;
                            n_wlen = r_wlen + 1'b1;
                        end else n_long = 1'b1;
                    end else begin
                        em_word = 1'b1;
                        fresh = 1'b1;
                    end
                end
                MODE_NUMBER: begin
                    if (!(is_digit(i_byte) || i_byte == ".")) begin
                        pr.v0 = 1'b1;
                        pr.t0 = mk(slb_pkg::KIND_LITERAL, r_beg, len_now, 8'd0, 8'd0, 1'b0);
                        fresh = 1'b1;
                    end
                end
                MODE_STRING: begin
                    if (i_byte == (r_dq ? 8'h22 : 8'h27)) begin
                        pr.v0 = 1'b1;
                        pr.t0 = mk(slb_pkg::KIND_LITERAL, r_beg,
                                   (r_pos >= r_beg) ? len_now : '0, 8'd0, 8'd0, 1'b0);
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_LINE: if (i_byte == 8'h0A || i_byte == 8'h0D) n_mode = MODE_IDLE;
                MODE_BLOCK: begin
                    if (r_star && i_byte == "/") begin
                        n_mode = MODE_IDLE;
                        n_star = 1'b0;
                    end else n_star = (i_byte == "*");
                end
                MODE_HELD: begin
                    n_held = '0;
                    if ((i_byte == "=" && (r_held == ">" || r_held == "<" || r_held == "!"))
                        || (r_held == "<" && i_byte == ">")) begin
                        pr.v0 = 1'b1;
                        pr.t0 = mk(slb_pkg::KIND_OPERATOR, r_beg, (PB+1)'(2), r_held, i_byte,
                                   1'b0);
                        n_mode = MODE_IDLE;
                    end else if (r_held == "-" && i_byte == "-") n_mode = MODE_LINE;
                    else if (r_held == "/" && i_byte == "*") begin
                        n_mode = MODE_BLOCK;
                        n_star = 1'b0;
                    end else begin
                        em_held = (r_held != "!");
                        fresh = 1'b1;
                    end
                end
                default: fresh = 1'b1;
            endcase
            if (em_held) begin
                pr.v0 = 1'b1;
                pr.t0 = mk(slb_pkg::KIND_OPERATOR, r_beg, (PB+1)'(1), r_held, 8'd0, 1'b0);
            end
            if (fresh) begin
                n_mode = MODE_IDLE;
                if (i_byte == 8'h27 || i_byte == 8'h22) begin
                    n_mode = MODE_STRING;
                    n_dq = (i_byte == 8'h22);
                    n_beg = (r_pos < slb_pkg::POS_MAX) ? r_pos + 1'b1 : slb_pkg::POS_MAX;
                end else if (is_digit(i_byte)) begin
                    n_mode = MODE_NUMBER;
                    n_beg = r_pos;
                end else if (is_alpha(i_byte) || i_byte == "_") begin
                    n_mode = MODE_IDENT;
                    n_word = '0;
                    n_word[7:0] = cu;
                    n_wlen = ($bits(n_wlen))'(1);
                    n_long = 1'b0;
                    n_beg = r_pos;
                end else if (i_byte == "-" || i_byte == "/" || i_byte == "<" || i_byte == ">"
                             || i_byte == "!") begin
                    n_mode = MODE_HELD;
                    n_held = i_byte;
                    n_beg = r_pos;
                end else if (i_byte == "=" || i_byte == "+" || i_byte == "*" || i_byte == "%"
                             || i_byte == "&" || i_byte == "|" || i_byte == "^") begin
                    pr.v1 = 1'b1;
                    pr.t1 = mk(slb_pkg::KIND_OPERATOR, r_pos, (PB+1)'(1), i_byte, 8'd0, 1'b0);
                end else if (i_byte == "(" || i_byte == ")" || i_byte == "," || i_byte == ";"
                             || i_byte == ".") begin
                    pr.v1 = 1'b1;
                    pr.t1 = mk(slb_pkg::KIND_PUNCT, r_pos, (PB+1)'(1), i_byte, 8'd0, 1'b0);
                end
            end
            if (r_pos < slb_pkg::POS_MAX) n_pos = r_pos + 1'b1;
        end
        if (em_word) begin
            pr.v0 = 1'b1;
            pr.v0_word = 1'b1;
            pr.word = r_word;
            pr.word_long = r_long;
            pr.t0 = mk(slb_pkg::KIND_IDENT, r_beg, len_now, 8'd0, 8'd0, 1'b0);
        end
    end

    assign o_push = fire && (pr.v0 || pr.v1);
    assign o_pair = pr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE; r_dq <= 1'b0; r_star <= 1'b0; r_long <= 1'b0;
            r_held <= '0; r_pos <= '0; r_beg <= '0; r_word <= '0; r_wlen <= '0;
        end else if (fire) begin
            r_mode <= n_mode; r_dq <= n_dq; r_star <= n_star; r_long <= n_long;
            r_held <= n_held; r_pos <= n_pos; r_beg <= n_beg; r_word <= n_word;
            r_wlen <= n_wlen;
        end
    end
endmodule

[design/slb_queue.sv]
// Short queue of token pairs between the scanner and the emitter.
// Depends on slb_pkg.
`timescale 1ns / 1ps
module slb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  slb_pkg::t_pair i_pair,
    output logic           o_room,
    output logic           o_valid,
    output slb_pkg::t_pair o_pair,
    input  logic           i_pop
);
    localparam int DEPTH = 4;
    slb_pkg::t_pair r_mem [DEPTH];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;

    // Room comes from the registered count alone, so ready does not depend on this cycle's pop.
    assign o_room = r_cnt < 3'(DEPTH);
    assign o_valid = r_cnt != 3'd0;
    assign o_pair = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_pair;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + 3'(i_push) - 3'(i_pop);
        end
    end
endmodule

[design/slb_back.sv]
// Back end: keyword match in parallel, then serialises each pair into tokens.
// Depends on slb_pkg.
`timescale 1ns / 1ps
module slb_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  slb_pkg::t_pair i_pair,
    output logic           o_pop,
    output logic           o_valid,
    output slb_pkg::t_token o_token,
    input  logic           i_ready
);
    // Stage 1 registers the keyword match; the output register follows.
    logic r_sv, r_hi;
    slb_pkg::t_pair r_sp;
    logic [5:0] r_kw;
    logic r_hit;
    logic r_ov;
    slb_pkg::t_token r_ot;

    logic hit;
    logic [5:0] kw;
    always_comb begin
        hit = 1'b0;
        kw = '0;
        for (int k = 0; k < slb_pkg::KEYWORD_COUNT; k++) begin
            if (i_pair.word == slb_pkg::kw_text(k)) begin
                hit = 1'b1;
                kw = 6'(k);
            end
        end
        hit = hit && !i_pair.word_long && i_pair.v0_word;
    end

    logic out_free, take_half, s_done, load0, load1;
    slb_pkg::t_token t0;
    assign out_free = !r_ov || i_ready;
    // r_hi marks that the first token of the staged pair has gone.
    assign load0 = r_sv && !r_hi && r_sp.v0;
    assign load1 = r_sv && (r_hi || !r_sp.v0) && r_sp.v1;
    assign take_half = out_free && r_sv;
    assign s_done = !r_sv || (take_half && (load1 || (load0 && !r_sp.v1)));
    assign o_pop = i_valid && s_done;

    always_comb begin
        t0 = r_sp.t0;
        if (r_hit) begin
            t0.token_kind = slb_pkg::KIND_KEYWORD;
            t0.keyword_number = r_kw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_sp <= i_pair;
            r_kw <= kw;
            r_hit <= hit;
        end
        if (take_half) r_ot <= load0 ? t0 : r_sp.t1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0; r_hi <= 1'b0; r_ov <= 1'b0;
        end else begin
            if (out_free) r_ov <= r_sv;
            if (s_done) begin
                r_sv <= o_pop;
                r_hi <= 1'b0;
            end else if (take_half) r_hi <= 1'b1;
        end
    end

    assign o_valid = r_ov;
    assign o_token = r_ot;
endmodule

[design/sql_lexer_byte_stream_top.sv]
// SQL lexer top level: scanner front end, pair queue, keyword/emit back end.
// Throughput one byte per cycle while the queue has room; a byte that yields two tokens sends both in turn.
// The first token passes the queue, the match stage and the output register before it is valid.
// Synchronous active-low reset clears scanner state, queue pointers and valid flags.
// Depends on slb_pkg, slb_if, slb_front, slb_queue, slb_back.
`timescale 1ns / 1ps
module sql_lexer_byte_stream_top (
    input logic       i_clk,
    input logic       i_rst_n,
    slb_in_if.sink    i_in,
    slb_out_if.source o_out
);
    logic push, room, qv, pop;
    slb_pkg::t_pair fp, qp;
    slb_pkg::t_token tok;

    slb_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_in.valid), .i_byte(i_in.text_byte),
        .i_end(i_in.end_of_text), .o_ready(i_in.ready), .o_push(push), .o_pair(fp),
        .i_room(room)
    );
    slb_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_pair(fp), .o_room(room),
        .o_valid(qv), .o_pair(qp), .i_pop(pop)
    );
    slb_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(qv), .i_pair(qp), .o_pop(pop),
        .o_valid(o_out.valid), .o_token(tok), .i_ready(o_out.ready)
    );

    assign o_out.token_kind = tok.token_kind;
    assign o_out.token_start = tok.token_start;
    assign o_out.token_length = tok.token_length;
    assign o_out.keyword_number = tok.keyword_number;
    assign o_out.first_symbol = tok.first_symbol;
    assign o_out.second_symbol = tok.second_symbol;
    assign o_out.last = tok.last;

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> room) else $error("queue written without room");
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> qv) else $error("queue read while empty");
    a_eof_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.last) |-> (o_out.token_length == 16'd0))
        else $error("end token carries a length");
endmodule
